// File: rtl/core/mfir_pkg.sv
// ----------------------------------------------------------------------------
// mfir_pkg
// shared constants, types and state codes of the multichannel fir filter unit
// ----------------------------------------------------------------------------
package mfir_pkg;

	// filter geometry
	localparam int CHANNELS  = 5;
	localparam int TAPS      = 5;
	localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TAP_IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;

	// field widths
	localparam int CH_W     = 3;
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 12;
	localparam int GAIN_W   = 12;

	// register file
	localparam int REG_W     = 60;
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 6;
	localparam int NUM_REGS  = 6;
	localparam int REG_IDX_W = ADDR_W - 3;

	localparam logic [REG_IDX_W-1:0] REG_COEF_BASE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAINS     = 3'd5;

	// datapath widths
	localparam int ACC_SHIFT  = 11;
	localparam int GAIN_SHIFT = 8;
	localparam int ACC_W      = 30;
	localparam int Y_W        = ACC_W - ACC_SHIFT;
	localparam int MUL_A_W    = Y_W;
	localparam int MUL_B_W    = GAIN_W + 1;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int SCALED_W   = PROD_W - GAIN_SHIFT;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic [GAIN_W-1:0]          gain_t;

	typedef logic [TAPS-1:0][COEF_W-1:0]     coef_row_t;
	typedef coef_row_t [CHANNELS-1:0]        coef_bank_t;
	typedef logic [CHANNELS-1:0][GAIN_W-1:0] gain_bank_t;

	// sequencer to shared multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic mul_en;
		logic gain_sel;
	} mac_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_GAIN,
		ST_DONE
	} state_t;

endpackage

// File: rtl/core/mfir_regs.sv
// ----------------------------------------------------------------------------
// mfir_regs
// apb register file holding coefficient sets and output gains
// ----------------------------------------------------------------------------
module mfir_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mfir_pkg::ADDR_W-1:0] paddr,
	input  logic [mfir_pkg::DATA_W-1:0] pwdata,
	output logic [mfir_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output mfir_pkg::coef_bank_t       coefs,
	output mfir_pkg::gain_bank_t       gains
);
	import mfir_pkg::*;

	logic [REG_W-1:0]     regs_q [NUM_REGS];
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 idx_valid;

	assign reg_idx   = paddr[ADDR_W-1:3];
	assign idx_valid = (reg_idx < REG_IDX_W'(NUM_REGS));
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (psel && penable && pwrite && idx_valid) begin
			regs_q[reg_idx] <= pwdata[REG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (idx_valid) begin
			prdata = {{(DATA_W-REG_W){1'b0}}, regs_q[reg_idx]};
		end
	end

	// unpack coefficient fields and gains
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			for (int t = 0; t < TAPS; t++) begin
				coefs[c][t] = regs_q[int'(REG_COEF_BASE) + c][t*COEF_W +: COEF_W];
			end
			gains[c] = regs_q[REG_GAINS][c*GAIN_W +: GAIN_W];
		end
	end

endmodule

// File: rtl/core/mfir_mac.sv
// ----------------------------------------------------------------------------
// mfir_mac
// shared multiplier with product register, accumulator and output saturation
// ----------------------------------------------------------------------------
module mfir_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  mfir_pkg::mac_ctrl_t ctrl,
	input  mfir_pkg::sample_t   sample,
	input  mfir_pkg::coef_t     coef,
	input  mfir_pkg::gain_t     gain,
	output mfir_pkg::sample_t   result
);
	import mfir_pkg::*;

	logic signed [MUL_A_W-1:0]  op_a;
	logic signed [MUL_B_W-1:0]  op_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   prod_q;
	logic                       prod_vld_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SCALED_W-1:0] scaled;
	logic                       fits;

	// operand select: tap product or gain product
	always_comb begin
		if (ctrl.gain_sel) begin
			op_a = acc_q[ACC_W-1:ACC_SHIFT];
			op_b = {1'b0, gain};
		end else begin
			op_a = {{(MUL_A_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
			op_b = {coef[COEF_W-1], coef};
		end
	end

	assign prod = op_a * op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_q <= 1'b0;
			acc_q      <= '0;
		end else if (ctrl.clear) begin
			prod_vld_q <= 1'b0;
			acc_q      <= '0;
		end else begin
			if (prod_vld_q) begin
				acc_q <= acc_q + prod_q[ACC_W-1:0];
			end
			prod_vld_q <= ctrl.mul_en && !ctrl.gain_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= prod;
		end
	end

	// floor shift then saturate to the sample width
	assign scaled = prod_q[PROD_W-1:GAIN_SHIFT];
	assign fits   = (scaled[SCALED_W-1:SAMPLE_W-1] ==
	                 {(SCALED_W-SAMPLE_W+1){scaled[SCALED_W-1]}});

	always_comb begin
		if (fits) begin
			result = scaled[SAMPLE_W-1:0];
		end else if (scaled[SCALED_W-1]) begin
			result = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			result = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

endmodule

// File: rtl/core/mfir_ctrl.sv
// ----------------------------------------------------------------------------
// mfir_ctrl
// sequencer, delay line store, write positions and result register
// ----------------------------------------------------------------------------
module mfir_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  logic [mfir_pkg::CH_W-1:0]  channel,
	input  mfir_pkg::sample_t          sample_in,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic [mfir_pkg::CH_W-1:0]  channel_out,
	output mfir_pkg::sample_t          filtered,
	input  mfir_pkg::coef_bank_t       coefs,
	input  mfir_pkg::gain_bank_t       gains,
	output mfir_pkg::mac_ctrl_t        mac_ctrl,
	output mfir_pkg::sample_t          mac_sample,
	output mfir_pkg::coef_t            mac_coef,
	output mfir_pkg::gain_t            mac_gain,
	input  mfir_pkg::sample_t          mac_result
);
	import mfir_pkg::*;

	state_t               state_q, state_d;
	sample_t              store_q [CHANNELS][TAPS];
	logic [TAP_IDX_W-1:0] pos_q [CHANNELS];
	logic [TAP_IDX_W-1:0] tap_q;
	logic [TAP_IDX_W-1:0] rd_q;
	logic [CH_W-1:0]      ch_q;
	logic                 in_range_q;
	logic                 result_valid_q;
	logic [CH_W-1:0]      channel_out_q;
	sample_t              filtered_q;

	logic                 accept;
	logic                 in_range;
	logic [CH_IDX_W-1:0]  ch_idx;
	logic [CH_IDX_W-1:0]  chq_idx;
	logic [TAP_IDX_W-1:0] cur_pos;
	logic                 load_out;

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign in_range     = (channel < CH_W'(CHANNELS));
	assign ch_idx       = channel[CH_IDX_W-1:0];
	assign chq_idx      = ch_q[CH_IDX_W-1:0];
	assign cur_pos      = pos_q[ch_idx];

	// delay lines and write positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pos_q[c] <= '0;
				for (int t = 0; t < TAPS; t++) begin
					store_q[c][t] <= '0;
				end
			end
		end else if (accept && in_range) begin
			store_q[ch_idx][cur_pos] <= sample_in;
			pos_q[ch_idx] <= (cur_pos == TAP_IDX_W'(TAPS-1)) ? '0 : cur_pos + 1'b1;
		end
	end

	// per-transaction context
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q       <= channel;
			in_range_q <= in_range;
			rd_q       <= cur_pos;
			tap_q      <= '0;
		end else if (state_q == ST_MAC) begin
			tap_q <= tap_q + 1'b1;
			rd_q  <= (rd_q == TAP_IDX_W'(TAPS-1)) ? '0 : rd_q + 1'b1;
		end
	end

	assign mac_sample = store_q[chq_idx][rd_q];
	assign mac_coef   = coefs[chq_idx][tap_q];
	assign mac_gain   = gains[chq_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mac_ctrl = '0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mac_ctrl.clear = 1'b1;
					state_d = in_range ? ST_MAC : ST_DONE;
				end
			end
			ST_MAC: begin
				mac_ctrl.mul_en = 1'b1;
				if (tap_q == TAP_IDX_W'(TAPS-1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_GAIN;
			end
			ST_GAIN: begin
				mac_ctrl.mul_en   = 1'b1;
				mac_ctrl.gain_sel = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			channel_out_q <= ch_q;
			filtered_q    <= in_range_q ? mac_result : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign channel_out  = channel_out_q;
	assign filtered     = filtered_q;

endmodule

// File: rtl/core/multichannel_fir_filter_unit.sv
// ----------------------------------------------------------------------------
// multichannel_fir_filter_unit
// five-channel five-tap fir filter with per-channel gain and saturation
// ----------------------------------------------------------------------------
// sequence: an in-range transaction runs the accept cycle, the five tap passes,
//   one accumulate drain, one gain pass through the single shared multiplier
//   and the result load; an out-of-range channel goes from accept to the
//   result load. A new input is taken only once the result is loaded, and a
//   stalled result holds off the next input
// reset: arst_n clears delay lines, write positions, registers and control
// ----------------------------------------------------------------------------
module multichannel_fir_filter_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mfir_pkg::ADDR_W-1:0] paddr,
	input  logic [mfir_pkg::DATA_W-1:0] pwdata,
	output logic [mfir_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	// sample channel
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  logic [mfir_pkg::CH_W-1:0]   channel,
	input  mfir_pkg::sample_t           sample_in,
	// result channel
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [mfir_pkg::CH_W-1:0]   channel_out,
	output mfir_pkg::sample_t           filtered
);
	import mfir_pkg::*;

	// unpacked register contents
	coef_bank_t coefs;
	gain_bank_t gains;

	// sequencer to shared arithmetic unit
	mac_ctrl_t  mac_ctrl;
	sample_t    mac_sample;
	coef_t      mac_coef;
	gain_t      mac_gain;
	sample_t    mac_result;

	// coefficient sets at 8*channel, gain word at 8*5
	mfir_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coefs   (coefs),
		.gains   (gains)
	);

	// sequencer: writes the new sample, walks the taps from the write
	// position, then runs the gain pass and loads the result register
	mfir_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.channel      (channel),
		.sample_in    (sample_in),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.channel_out  (channel_out),
		.filtered     (filtered),
		.coefs        (coefs),
		.gains        (gains),
		.mac_ctrl     (mac_ctrl),
		.mac_sample   (mac_sample),
		.mac_coef     (mac_coef),
		.mac_gain     (mac_gain),
		.mac_result   (mac_result)
	);

	// one 19x13 signed multiplier shared by tap products and the gain
	// product, with a product register ahead of the accumulator
	mfir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.sample (mac_sample),
		.coef   (mac_coef),
		.gain   (mac_gain),
		.result (mac_result)
	);

endmodule
